[design/sdga_pkg.sv]
// Shared types and codes for the space-to-depth group average block.
`timescale 1ns / 1ps

package sdga_pkg;

    localparam logic [2:0] CFG_INPUT_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_INPUT_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_INPUT_DEPTH    = 3'd2;
    localparam logic [2:0] CFG_INPUT_CHANNELS = 3'd3;
    localparam logic [2:0] CFG_OUT_CHANNELS   = 3'd4;
    localparam logic [2:0] CFG_TEMPORAL       = 3'd5;
    localparam logic [2:0] CFG_SPATIAL        = 3'd6;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_COMPUTE = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_SHAPE = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIVW,
        S_DIVH,
        S_DIVG,
        S_DIVD,
        S_POS,
        S_E0,
        S_DIVE,
        S_DIVT,
        S_DIVY,
        S_EA,
        S_EB,
        S_EC,
        S_SGO,
        S_DIVS,
        S_OUT
    } t_state;

endpackage

[design/sdga_div.sv]
// Unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module sdga_div #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quotient,
    output logic [WIDTH-1:0] o_remainder
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_q;
    logic [WIDTH-1:0] r_r;
    logic [WIDTH-1:0] r_d;
    logic [CW-1:0]    r_cnt;
    logic             r_run;
    logic             r_done;
    logic [WIDTH:0]   trial;
    logic             fits;

    assign trial = {r_r, r_q[WIDTH-1]};
    assign fits  = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CW'(WIDTH);
            end else if (r_run) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_run) begin
            r_q <= {r_q[WIDTH-2:0], fits};
            r_r <= fits ? WIDTH'(trial - {1'b0, r_d}) : trial[WIDTH-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_r;

endmodule

[design/space_to_depth_group_average.sv]
// Space-to-depth group average: sample store plus sequencer for one average per request.
`timescale 1ns / 1ps

// A load word writes one sample into the store, if its address lies inside the store. A
// compute word keeps busy high while eight divisions run through one shared bit-serial
// divider (shape checks, start offset split, final mean) and each of the G elements averaged
// passes through the store's single read port (address product, read, accumulate), or is
// skipped when its frame lies in the front padding. A shape or position error returns after
// the first four divisions, a register out of range straight from idle. The result is
// shown for one cycle on o_strobe and cannot be held off. The store needs no clearing
// after reset.
module space_to_depth_group_average import sdga_pkg::*; #(
    parameter int MAX_ELEMENTS = 4096,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_kind,
    input  logic [11:0]        i_load_address,
    input  logic signed [15:0] i_sample_value,
    input  logic [9:0]         i_out_channel,
    input  logic [5:0]         i_out_frame,
    input  logic [7:0]         i_out_row,
    input  logic [7:0]         i_out_column,
    output logic               o_strobe,
    output logic signed [15:0] o_average_value,
    output logic [1:0]         o_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [10:0]        i_cfg_data
);

    localparam int          AW    = $clog2(MAX_ELEMENTS);
    localparam int          SUM_W = SAMPLE_BITS + 16;
    localparam logic [31:0] MAX_E = 32'(MAX_ELEMENTS);

    t_state r_state, n_state;

    logic [8:0]  r_w, r_h;
    logic [6:0]  r_d, r_c;
    logic [10:0] r_oc;
    logic [3:0]  r_ft, r_fs;

    logic [6:0]  r_fss;
    logic [16:0] r_hw;
    logic [9:0]  r_ftfss;
    logic [22:0] r_dhw;
    logic [28:0] r_tot;
    logic [15:0] r_totg;

    logic [9:0]  r_chan;
    logic [5:0]  r_frame;
    logic [7:0]  r_row, r_col;
    logic        r_bad;
    logic [8:0]  r_out_w, r_out_h;
    logic [15:0] r_group;
    logic [6:0]  r_out_d;
    logic [2:0]  r_pad;
    logic [15:0] r_e0;
    logic [9:0]  r_fbase;
    logic [10:0] r_rbase, r_cbase;
    logic [6:0]  r_src_c;
    logic [2:0]  r_st, r_sy, r_sx;
    logic [15:0] r_g;
    logic [31:0] r_p1, r_p2, r_p3, r_px;
    logic        r_rd_ok;
    logic [SUM_W-1:0] r_sum;
    logic        r_neg;
    logic [15:0] r_avg;
    logic [1:0]  r_status;

    logic [SAMPLE_BITS-1:0] mem [MAX_ELEMENTS];
    logic [SAMPLE_BITS-1:0] r_rd_data;

    logic             div_go;
    logic [SUM_W-1:0] div_a, div_b, div_q, div_r;
    logic             div_done;

    logic             range_bad, shape_bad, pos_bad;
    logic             x_end, y_end, t_end, last;
    logic [9:0]       pt, ptm, pad_full;
    logic             skip;
    logic [10:0]      rowi;
    logic [31:0]      idx;
    logic [31:0]      la32;
    logic             la_ok, do_load;
    logic [SAMPLE_BITS+15:0] wr_ext;
    logic [SUM_W-1:0] rd_ext, sum_mag;
    logic             accept;

    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign o_cfg_ready = !busy;
    assign o_strobe = (r_state == S_OUT);
    assign o_average_value = r_avg;
    assign o_status = r_status;

    assign range_bad = (r_w == 9'd0) || (r_w > 9'd256) || (r_h == 9'd0) || (r_h > 9'd256) ||
                       (r_d == 7'd0) || (r_d > 7'd64) || (r_c == 7'd0) || (r_c > 7'd64) ||
                       (r_oc == 11'd0) || (r_oc > 11'd1024) || (r_ft == 4'd0) ||
                       (r_ft > 4'd8) || (r_fs == 4'd0) || (r_fs > 4'd8);
    assign shape_bad = r_bad || (32'(r_tot) > MAX_E);
    assign pos_bad   = ({1'b0, r_chan} >= r_oc) || ({1'b0, r_frame} >= r_out_d) ||
                       ({1'b0, r_row} >= r_out_h) || ({1'b0, r_col} >= r_out_w);

    assign x_end = ({1'b0, r_sx} == r_fs - 4'd1);
    assign y_end = ({1'b0, r_sy} == r_fs - 4'd1);
    assign t_end = ({1'b0, r_st} == r_ft - 4'd1);
    assign last  = (r_g == r_group - 16'd1);

    assign pt       = r_fbase + 10'(r_st);
    assign skip     = pt < 10'(r_pad);
    assign ptm      = pt - 10'(r_pad);
    assign rowi     = r_rbase + 11'(r_sy);
    assign idx      = r_p1 + r_p2 + r_p3 + r_px;
    assign pad_full = 10'(r_out_d) * 10'(r_ft) - 10'(r_d);

    assign la32    = 32'(i_load_address);
    assign la_ok   = la32 < MAX_E;
    assign do_load = accept && (i_kind == KIND_LOAD) && la_ok;
    assign wr_ext  = {{SAMPLE_BITS{i_sample_value[15]}}, i_sample_value};
    assign rd_ext  = {{16{r_rd_data[SAMPLE_BITS-1]}}, r_rd_data};
    assign sum_mag = r_sum[SUM_W-1] ? (~r_sum + SUM_W'(1)) : r_sum;

    sdga_div #(.WIDTH(SUM_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_go),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quotient (div_q),
        .o_remainder(div_r)
    );

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            mem[la32[AW-1:0]] <= wr_ext[SAMPLE_BITS-1:0];
        end
        if (r_state == S_EB) begin
            r_rd_data <= mem[idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w  <= 9'd1;
            r_h  <= 9'd1;
            r_d  <= 7'd1;
            r_c  <= 7'd1;
            r_oc <= 11'd0;
            r_ft <= 4'd1;
            r_fs <= 4'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_INPUT_WIDTH:    r_w  <= i_cfg_data[8:0];
                CFG_INPUT_HEIGHT:   r_h  <= i_cfg_data[8:0];
                CFG_INPUT_DEPTH:    r_d  <= i_cfg_data[6:0];
                CFG_INPUT_CHANNELS: r_c  <= i_cfg_data[6:0];
                CFG_OUT_CHANNELS:   r_oc <= i_cfg_data;
                CFG_TEMPORAL:       r_ft <= i_cfg_data[3:0];
                CFG_SPATIAL:        r_fs <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // derived shape products, registered in a chain (r_fss and r_hw, then r_ftfss and r_dhw, then r_tot and r_totg)
    always_ff @(posedge i_clk) begin
        r_fss   <= 7'(r_fs) * 7'(r_fs);
        r_hw    <= 17'(r_w) * 17'(r_h);
        r_ftfss <= 10'(r_ft) * 10'(r_fss);
        r_dhw   <= 23'(r_d) * 23'(r_hw);
        r_tot   <= 29'(r_c) * 29'(r_dhw);
        r_totg  <= 16'(r_c) * 16'(r_ftfss);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        div_go  = 1'b0;
        div_a   = '0;
        div_b   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start && i_kind == KIND_COMPUTE) begin
                    if (range_bad) begin
                        n_state = S_OUT;
                    end else begin
                        div_go  = 1'b1;
                        div_a   = SUM_W'(r_w);
                        div_b   = SUM_W'(r_fs);
                        n_state = S_DIVW;
                    end
                end
            end
            S_DIVW: begin
                if (div_done) begin
                    div_go  = 1'b1;
                    div_a   = SUM_W'(r_h);
                    div_b   = SUM_W'(r_fs);
                    n_state = S_DIVH;
                end
            end
            S_DIVH: begin
                if (div_done) begin
                    div_go  = 1'b1;
                    div_a   = SUM_W'(r_totg);
                    div_b   = SUM_W'(r_oc);
                    n_state = S_DIVG;
                end
            end
            S_DIVG: begin
                if (div_done) begin
                    div_go  = 1'b1;
                    div_a   = SUM_W'(r_d) + SUM_W'(r_ft) - SUM_W'(1);
                    div_b   = SUM_W'(r_ft);
                    n_state = S_DIVD;
                end
            end
            S_DIVD: begin
                if (div_done) begin
                    n_state = S_POS;
                end
            end
            S_POS: begin
                if (shape_bad || pos_bad) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_E0;
                end
            end
            S_E0: begin
                div_go  = 1'b1;
                div_a   = SUM_W'(r_e0);
                div_b   = SUM_W'(r_ftfss);
                n_state = S_DIVE;
            end
            S_DIVE: begin
                if (div_done) begin
                    div_go  = 1'b1;
                    div_a   = div_r;
                    div_b   = SUM_W'(r_fss);
                    n_state = S_DIVT;
                end
            end
            S_DIVT: begin
                if (div_done) begin
                    div_go  = 1'b1;
                    div_a   = div_r;
                    div_b   = SUM_W'(r_fs);
                    n_state = S_DIVY;
                end
            end
            S_DIVY: begin
                if (div_done) begin
                    n_state = S_EA;
                end
            end
            S_EA: begin
                if (skip) begin
                    if (last) begin
                        n_state = S_SGO;
                    end
                end else begin
                    n_state = S_EB;
                end
            end
            S_EB: n_state = S_EC;
            S_EC: n_state = last ? S_SGO : S_EA;
            S_SGO: begin
                div_go  = 1'b1;
                div_a   = sum_mag;
                div_b   = SUM_W'(r_group);
                n_state = S_DIVS;
            end
            S_DIVS: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_chan   <= i_out_channel;
                r_frame  <= i_out_frame;
                r_row    <= i_out_row;
                r_col    <= i_out_column;
                r_bad    <= 1'b0;
                r_status <= STAT_SHAPE;
                r_avg    <= '0;
            end
            S_DIVW: begin
                if (div_done) begin
                    r_out_w <= div_q[8:0];
                    if (div_r != '0) r_bad <= 1'b1;
                end
            end
            S_DIVH: begin
                if (div_done) begin
                    r_out_h <= div_q[8:0];
                    if (div_r != '0) r_bad <= 1'b1;
                end
            end
            S_DIVG: begin
                if (div_done) begin
                    r_group <= div_q[15:0];
                    if (div_q == '0 || div_r != '0) r_bad <= 1'b1;
                end
            end
            S_DIVD: begin
                if (div_done) r_out_d <= div_q[6:0];
            end
            S_POS: begin
                r_pad   <= pad_full[2:0];
                r_e0    <= 16'(r_chan) * r_group;
                r_fbase <= 10'(r_frame) * 10'(r_ft);
                r_rbase <= 11'(r_row) * 11'(r_fs);
                r_cbase <= 11'(r_col) * 11'(r_fs);
                r_sum   <= '0;
                r_g     <= '0;
                if (shape_bad) begin
                    r_status <= STAT_SHAPE;
                end else if (pos_bad) begin
                    r_status <= STAT_RANGE;
                end
            end
            S_E0: ;
            S_DIVE: begin
                if (div_done) r_src_c <= div_q[6:0];
            end
            S_DIVT: begin
                if (div_done) r_st <= div_q[2:0];
            end
            S_DIVY: begin
                if (div_done) begin
                    r_sy <= div_q[2:0];
                    r_sx <= div_r[2:0];
                end
            end
            S_EA: begin
                if (skip) begin
                    r_g <= r_g + 16'd1;
                    r_sx <= x_end ? 3'd0 : r_sx + 3'd1;
                    if (x_end) begin
                        r_sy <= y_end ? 3'd0 : r_sy + 3'd1;
                        if (y_end) begin
                            r_st <= t_end ? 3'd0 : r_st + 3'd1;
                            if (t_end) r_src_c <= r_src_c + 7'd1;
                        end
                    end
                end else begin
                    r_p1 <= 32'(r_src_c) * 32'(r_dhw);
                    r_p2 <= 32'(ptm) * 32'(r_hw);
                    r_p3 <= 32'(rowi) * 32'(r_w);
                    r_px <= 32'(r_cbase) + 32'(r_sx);
                end
            end
            S_EB: r_rd_ok <= idx < MAX_E;
            S_EC: begin
                if (r_rd_ok) r_sum <= r_sum + rd_ext;
                r_g <= r_g + 16'd1;
                r_sx <= x_end ? 3'd0 : r_sx + 3'd1;
                if (x_end) begin
                    r_sy <= y_end ? 3'd0 : r_sy + 3'd1;
                    if (y_end) begin
                        r_st <= t_end ? 3'd0 : r_st + 3'd1;
                        if (t_end) r_src_c <= r_src_c + 7'd1;
                    end
                end
            end
            S_SGO: r_neg <= r_sum[SUM_W-1];
            S_DIVS: begin
                if (div_done) begin
                    r_avg    <= r_neg ? (16'd0 - div_q[15:0]) : div_q[15:0];
                    r_status <= STAT_OK;
                end
            end
            S_OUT: ;
            default: ;
        endcase
    end

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held longer than one cycle");

    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == KIND_LOAD) |=> !busy && !o_strobe)
        else $error("load word started a computation");

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == KIND_COMPUTE) |=> busy)
        else $error("compute word not taken");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != STAT_OK) |-> (o_average_value == 16'sd0))
        else $error("error result carries a nonzero average");

endmodule
